[hdl/xbt_pkg.sv]
// Shared types, codes and helper functions of the XML byte tokenizer.
`default_nettype none
package xbt_pkg;

  localparam int EntityMaxChars = 16;
  localparam int EntLenW = $clog2(EntityMaxChars + 1);
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  typedef enum logic [3:0] {
    M_TEXT, M_CDATA, M_LT, M_BANG, M_BANG_DASH, M_COMMENT, M_ENTITY,
    M_TAG, M_IDENT, M_QUOTE, M_QMARK, M_SLASH, M_ERR
  } mode_t;

  typedef enum logic [1:0] {B_DEC, B_OCT, B_HEX, B_ZERO} base_t;

  typedef enum logic [1:0] {K_CONTENT, K_SPACE, K_TOKEN, K_ERROR} kind_t;

  typedef enum logic [3:0] {
    T_END, T_LT, T_GT, T_PI_OPEN, T_PI_CLOSE, T_CLOSE_OPEN, T_EMPTY_CLOSE,
    T_BANG, T_IDENT, T_EQ, T_QUOTED, T_CDATA
  } tok_t;

  typedef enum logic [3:0] {
    E_BAD_TAG, E_EOF_TAG, E_EOF_QUOTE, E_BAD_COMMENT, E_EOF_COMMENT,
    E_EOF_ENTITY, E_EMPTY, E_UNKNOWN, E_TOO_LONG
  } err_t;

  // One result request.
  typedef struct packed {
    kind_t      kind;
    tok_t       token;
    logic [7:0] value;
    err_t       error_code;
    logic       last;
  } res_t;

  // Work of one input byte: up to two result requests.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } work_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic res_t mk(input kind_t k, input tok_t t, input logic [7:0] v,
                              input err_t e);
    res_t r;
    r.kind = k;
    r.token = t;
    r.value = v;
    r.error_code = e;
    r.last = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/xbt_front.sv]
// Front part: classifies each byte, keeps the lexer state and builds result requests.
`default_nettype none
module xbt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [7:0]     byte_in,
  input  wire logic           end_of_input,
  output xbt_pkg::work_t      work
);

  xbt_pkg::mode_t mode, mode_next;
  logic [1:0] dash_count, dash_count_next;
  logic [7:0] entity_value, entity_value_next;
  xbt_pkg::base_t entity_base, entity_base_next;
  logic [xbt_pkg::EntLenW-1:0] entity_length, entity_length_next;
  logic [3:0] entity_name_match, entity_name_match_next;

  xbt_pkg::res_t rq [2];
  logic [1:0] n;
  logic [7:0] c;
  logic [3:0] hv;
  logic hok;
  logic [3:0] m;
  logic ok_lt, ok_gt, ok_amp;

  always_comb begin
    c = byte_in;
    mode_next = mode;
    dash_count_next = dash_count;
    entity_value_next = entity_value;
    entity_base_next = entity_base;
    entity_length_next = entity_length;
    entity_name_match_next = entity_name_match;
    n = 2'd0;
    rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
    rq[1] = rq[0];
    hok = 1'b1;
    hv = 4'd0;
    m = entity_name_match;
    ok_lt = 1'b0;
    ok_gt = 1'b0;
    ok_amp = 1'b0;
    if (end_of_input) begin
      case (mode)
        xbt_pkg::M_TEXT: begin
          rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
          n = 2'd1;
        end
        xbt_pkg::M_CDATA: begin
          rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_CDATA, 8'd0, xbt_pkg::E_BAD_TAG);
          rq[1] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
          n = 2'd2;
          mode_next = xbt_pkg::M_TEXT;
        end
        xbt_pkg::M_LT, xbt_pkg::M_BANG, xbt_pkg::M_IDENT: begin
          rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN,
                              mode == xbt_pkg::M_LT ? xbt_pkg::T_LT :
                              mode == xbt_pkg::M_BANG ? xbt_pkg::T_BANG : xbt_pkg::T_IDENT,
                              8'd0, xbt_pkg::E_BAD_TAG);
          rq[1] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0, xbt_pkg::E_EOF_TAG);
          n = 2'd2;
          mode_next = xbt_pkg::M_ERR;
        end
        xbt_pkg::M_ERR: ;
        default: begin
          n = 2'd1;
          mode_next = xbt_pkg::M_ERR;
          case (mode)
            xbt_pkg::M_BANG_DASH:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_BAD_COMMENT);
            xbt_pkg::M_COMMENT:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_EOF_COMMENT);
            xbt_pkg::M_ENTITY:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_EOF_ENTITY);
            xbt_pkg::M_TAG:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_EOF_TAG);
            xbt_pkg::M_QUOTE:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_EOF_QUOTE);
            default:
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_BAD_TAG);
          endcase
        end
      endcase
    end else begin
      // Bytes that move to tag mode are handled by the tag rules below.
      logic do_tag;
      do_tag = 1'b0;
      case (mode)
        xbt_pkg::M_TEXT, xbt_pkg::M_CDATA: begin
          if (mode == xbt_pkg::M_TEXT && xbt_pkg::is_space(c)) begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_SPACE, xbt_pkg::T_CDATA, c, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
          end else if (c == "<") begin
            if (mode == xbt_pkg::M_CDATA) begin
              rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_CDATA, 8'd0,
                                  xbt_pkg::E_BAD_TAG);
              n = 2'd1;
            end
            mode_next = xbt_pkg::M_LT;
          end else if (c == "&") begin
            entity_value_next = 8'd0;
            entity_base_next = xbt_pkg::B_DEC;
            entity_length_next = '0;
            entity_name_match_next = 4'hF;
            mode_next = xbt_pkg::M_ENTITY;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, c, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            mode_next = xbt_pkg::M_CDATA;
          end
        end
        xbt_pkg::M_LT: begin
          if (c == "/") begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_CLOSE_OPEN, 8'd0,
                                xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            mode_next = xbt_pkg::M_TAG;
          end else if (c == "?") begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_PI_OPEN, 8'd0,
                                xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            mode_next = xbt_pkg::M_TAG;
          end else if (c == "!") begin
            mode_next = xbt_pkg::M_BANG;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_LT, 8'd0, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            do_tag = 1'b1;
          end
        end
        xbt_pkg::M_BANG: begin
          if (c == "-") begin
            mode_next = xbt_pkg::M_BANG_DASH;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_BANG, 8'd0, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            do_tag = 1'b1;
          end
        end
        xbt_pkg::M_BANG_DASH: begin
          if (c == "-") begin
            dash_count_next = 2'd0;
            mode_next = xbt_pkg::M_COMMENT;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                xbt_pkg::E_BAD_COMMENT);
            n = 2'd1;
            mode_next = xbt_pkg::M_ERR;
          end
        end
        xbt_pkg::M_COMMENT: begin
          if (c == "-") begin
            if (dash_count < 2'd2) dash_count_next = dash_count + 2'd1;
          end else if (c == ">" && dash_count >= 2'd2) begin
            dash_count_next = 2'd0;
            mode_next = xbt_pkg::M_TEXT;
          end else begin
            dash_count_next = 2'd0;
          end
        end
        xbt_pkg::M_ENTITY: begin
          if (c == ";") begin
            if (entity_length == '0) begin
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0, xbt_pkg::E_EMPTY);
              n = 2'd1;
              mode_next = xbt_pkg::M_ERR;
            end else begin
              n = 2'd1;
              mode_next = xbt_pkg::M_CDATA;
              if (m[0] && entity_length == xbt_pkg::EntLenW'(2))
                rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, "<",
                                    xbt_pkg::E_BAD_TAG);
              else if (m[1] && entity_length == xbt_pkg::EntLenW'(2))
                rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, ">",
                                    xbt_pkg::E_BAD_TAG);
              else if (m[2] && entity_length == xbt_pkg::EntLenW'(3))
                rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, "&",
                                    xbt_pkg::E_BAD_TAG);
              else if (m[3] && entity_length >= xbt_pkg::EntLenW'(2) &&
                       !(entity_base == xbt_pkg::B_HEX &&
                         entity_length == xbt_pkg::EntLenW'(3)))
                rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, entity_value,
                                    xbt_pkg::E_BAD_TAG);
              else begin
                rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                    xbt_pkg::E_UNKNOWN);
                mode_next = xbt_pkg::M_ERR;
              end
            end
          end else if (!xbt_pkg::is_space(c)) begin
            if (entity_length >= xbt_pkg::EntLenW'(xbt_pkg::EntityMaxChars)) begin
              rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0,
                                  xbt_pkg::E_TOO_LONG);
              n = 2'd1;
              mode_next = xbt_pkg::M_ERR;
            end else begin
              // Narrow match of the named entities by position.
              case (entity_length)
                xbt_pkg::EntLenW'(0): begin
                  ok_lt = c == "l"; ok_gt = c == "g"; ok_amp = c == "a";
                end
                xbt_pkg::EntLenW'(1): begin
                  ok_lt = c == "t"; ok_gt = c == "t"; ok_amp = c == "m";
                end
                xbt_pkg::EntLenW'(2): ok_amp = c == "p";
                default: ;
              endcase
              if (!ok_lt) m[0] = 1'b0;
              if (!ok_gt) m[1] = 1'b0;
              if (!ok_amp) m[2] = 1'b0;
              if (xbt_pkg::is_digit(c)) hv = 4'(c - "0");
              else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
              else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
              else hok = 1'b0;
              if (entity_length == '0) begin
                if (c != "#") m[3] = 1'b0;
              end else if (m[3]) begin
                if (entity_length == xbt_pkg::EntLenW'(1)) begin
                  if (c == "0") begin
                    entity_base_next = xbt_pkg::B_ZERO;
                    entity_value_next = 8'd0;
                  end else if (xbt_pkg::is_digit(c)) begin
                    entity_base_next = xbt_pkg::B_DEC;
                    entity_value_next = c - "0";
                  end else m[3] = 1'b0;
                end else begin
                  case (entity_base)
                    xbt_pkg::B_ZERO: begin
                      if (c == "x" || c == "X") entity_base_next = xbt_pkg::B_HEX;
                      else if (c >= "0" && c <= "7") begin
                        entity_base_next = xbt_pkg::B_OCT;
                        entity_value_next = c - "0";
                      end else m[3] = 1'b0;
                    end
                    xbt_pkg::B_DEC: begin
                      if (xbt_pkg::is_digit(c))
                        entity_value_next = (entity_value << 3) + (entity_value << 1)
                                            + (c - "0");
                      else m[3] = 1'b0;
                    end
                    xbt_pkg::B_OCT: begin
                      if (c >= "0" && c <= "7")
                        entity_value_next = (entity_value << 3) + (c - "0");
                      else m[3] = 1'b0;
                    end
                    default: begin
                      if (hok) entity_value_next = (entity_value << 4) + {4'd0, hv};
                      else m[3] = 1'b0;
                    end
                  endcase
                end
              end
              entity_name_match_next = m;
              entity_length_next = entity_length + xbt_pkg::EntLenW'(1);
            end
          end
        end
        xbt_pkg::M_TAG: do_tag = 1'b1;
        xbt_pkg::M_IDENT: begin
          if (xbt_pkg::is_alpha(c) || xbt_pkg::is_digit(c) || c == "_" || c == "!" ||
              c == ":" || c == "-") begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_IDENT, c, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_IDENT, 8'd0, xbt_pkg::E_BAD_TAG);
            n = 2'd1;
            do_tag = 1'b1;
          end
        end
        xbt_pkg::M_QUOTE: begin
          n = 2'd1;
          if (c == "\"") begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_QUOTED, 8'd0, xbt_pkg::E_BAD_TAG);
            mode_next = xbt_pkg::M_TAG;
          end else
            rq[0] = xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_QUOTED, c, xbt_pkg::E_BAD_TAG);
        end
        xbt_pkg::M_QMARK, xbt_pkg::M_SLASH: begin
          n = 2'd1;
          if (c == ">") begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_TOKEN,
                                mode == xbt_pkg::M_QMARK ? xbt_pkg::T_PI_CLOSE
                                                         : xbt_pkg::T_EMPTY_CLOSE,
                                8'd0, xbt_pkg::E_BAD_TAG);
            mode_next = xbt_pkg::M_TEXT;
          end else begin
            rq[0] = xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
            mode_next = xbt_pkg::M_ERR;
          end
        end
        default: ;
      endcase
      if (do_tag) begin
        mode_next = xbt_pkg::M_TAG;
        if (!xbt_pkg::is_space(c)) begin
          if (c == "?") mode_next = xbt_pkg::M_QMARK;
          else if (c == "/") mode_next = xbt_pkg::M_SLASH;
          else if (c == "\"") mode_next = xbt_pkg::M_QUOTE;
          else begin
            rq[n[0]] = c == ">" ?
              xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_GT, 8'd0, xbt_pkg::E_BAD_TAG) :
              c == "=" ?
              xbt_pkg::mk(xbt_pkg::K_TOKEN, xbt_pkg::T_EQ, 8'd0, xbt_pkg::E_BAD_TAG) :
              (xbt_pkg::is_alpha(c) || c == "_" || c == "!") ?
              xbt_pkg::mk(xbt_pkg::K_CONTENT, xbt_pkg::T_IDENT, c, xbt_pkg::E_BAD_TAG) :
              xbt_pkg::mk(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
            n = n + 2'd1;
            if (c == ">") mode_next = xbt_pkg::M_TEXT;
            else if (c == "=") mode_next = xbt_pkg::M_TAG;
            else if (xbt_pkg::is_alpha(c) || c == "_" || c == "!")
              mode_next = xbt_pkg::M_IDENT;
            else mode_next = xbt_pkg::M_ERR;
          end
        end
      end
    end
    if (n == 2'd1) rq[0].last = 1'b1;
    if (n == 2'd2) rq[1].last = 1'b1;
  end

  always_comb begin
    work.count = in_valid ? n : 2'd0;
    work.r0 = rq[0];
    work.r1 = rq[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= xbt_pkg::M_TEXT;
      dash_count <= 2'd0;
      entity_value <= 8'd0;
      entity_base <= xbt_pkg::B_DEC;
      entity_length <= '0;
      entity_name_match <= 4'hF;
    end else if (in_valid) begin
      mode <= mode_next;
      dash_count <= dash_count_next;
      entity_value <= entity_value_next;
      entity_base <= entity_base_next;
      entity_length <= entity_length_next;
      entity_name_match <= entity_name_match_next;
    end
  end

endmodule
`default_nettype wire

[hdl/xbt_back.sv]
// Back part: a small result queue that takes up to two requests a cycle and hands out one.
`default_nettype none
module xbt_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  xbt_pkg::work_t      work,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output xbt_pkg::res_t       head
);

  xbt_pkg::res_t mem [xbt_pkg::QueueDepth];
  logic [xbt_pkg::QueuePtrW-1:0] rd_ptr, wr_ptr;
  logic [xbt_pkg::QueuePtrW:0] fill, fill_next;
  logic do_pop;

  assign empty = fill == '0;
  // Room for two requests must remain whatever is popped this cycle.
  assign full = fill > (xbt_pkg::QueuePtrW+1)'(xbt_pkg::QueueDepth - 2);
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];
  assign fill_next = fill + {{(xbt_pkg::QueuePtrW-1){1'b0}}, work.count}
                     - {{xbt_pkg::QueuePtrW{1'b0}}, do_pop};

  always_ff @(posedge clk) begin
    if (work.count != 2'd0) mem[wr_ptr] <= work.r0;
    if (work.count == 2'd2) mem[wr_ptr + xbt_pkg::QueuePtrW'(1)] <= work.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + xbt_pkg::QueuePtrW'(work.count);
      if (do_pop) rd_ptr <= rd_ptr + xbt_pkg::QueuePtrW'(1);
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

[hdl/xml_byte_tokenizer_core.sv]
// Top level of the XML byte tokenizer: front classifier and back result queue.
//
//  channel  | handshake        | payload
//  input    | push / full      | byte_in, end_of_input
//  result   | pop / empty      | kind, token, value, error_code, last
//
// One byte is accepted per cycle unless full; its results enter the queue on the
// same edge and can be popped from the next cycle on. The queue holds four results
// and raises full when fewer than two places would be free, so pushing pauses only
// while the consumer lags. Synchronous reset clears the lexer state and the queue.
`default_nettype none
module xml_byte_tokenizer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_input,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      kind,
  output logic [3:0]      token,
  output logic [7:0]      value,
  output logic [3:0]      error_code,
  output logic            last
);

  xbt_pkg::work_t work;
  xbt_pkg::res_t head;
  logic accept;

  assign accept = push && !full;

  xbt_front u_front (
    .clk(clk), .rst(rst), .in_valid(accept), .byte_in(byte_in),
    .end_of_input(end_of_input), .work(work)
  );

  xbt_back u_back (
    .clk(clk), .rst(rst), .work(work), .full(full), .empty(empty), .pop(pop), .head(head)
  );

  assign kind = head.kind;
  assign token = head.token;
  assign value = head.value;
  assign error_code = head.error_code;
  assign last = head.last;

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> work.count == 2'd0) else $error("request written while queue full");

  a_two_has_last: assert property (@(posedge clk) disable iff (rst)
    work.count == 2'd2 |-> work.r1.last && !work.r0.last)
    else $error("last flag misplaced on paired requests");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty) else $error("queue full and empty at once");

endmodule
`default_nettype wire

[tb/sv/xml_byte_tokenizer_core_tb.sv]
// Self-checking testbench for the XML byte tokenizer core.
`timescale 1ns / 100ps
`default_nettype none
module xml_byte_tokenizer_core_tb;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] byte_in = 8'd0;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] kind;
  logic [3:0] token;
  logic [7:0] value;
  logic [3:0] error_code;
  logic       last;

  xml_byte_tokenizer_core DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .byte_in(byte_in),
    .end_of_input(end_of_input), .empty(empty), .pop(pop), .kind(kind),
    .token(token), .value(value), .error_code(error_code), .last(last)
  );

  always #5 clk = ~clk;

  // Lexer state of the predictor.
  xbt_pkg::mode_t lex_mode;
  logic [1:0]     dashes;
  logic [7:0]     ent_val;
  xbt_pkg::base_t ent_base;
  int             ent_len;
  logic [3:0]     ent_match;

  xbt_pkg::res_t token_q[$];
  xbt_pkg::res_t step_res[$];
  int   failures = 0;
  int   bytes_sent = 0;
  bit   burst = 0;
  bit   hold_req = 0;

  function automatic bit blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic note(input xbt_pkg::kind_t k, input xbt_pkg::tok_t t, input logic [7:0] v,
                      input xbt_pkg::err_t e);
    xbt_pkg::res_t r;
    r.kind = k;
    r.token = t;
    r.value = v;
    r.error_code = e;
    r.last = 1'b0;
    if (step_res.size() < 2) step_res.push_back(r);
  endtask

  task automatic lex_fail(input xbt_pkg::err_t e);
    note(xbt_pkg::K_ERROR, xbt_pkg::T_END, 8'd0, e);
    lex_mode = xbt_pkg::M_ERR;
  endtask

  task automatic lex_tag(input logic [7:0] c);
    if (blank(c)) return;
    if (c == "?") lex_mode = xbt_pkg::M_QMARK;
    else if (c == ">") begin
      note(xbt_pkg::K_TOKEN, xbt_pkg::T_GT, 8'd0, xbt_pkg::E_BAD_TAG);
      lex_mode = xbt_pkg::M_TEXT;
    end else if (c == "/") lex_mode = xbt_pkg::M_SLASH;
    else if (c == "=") note(xbt_pkg::K_TOKEN, xbt_pkg::T_EQ, 8'd0, xbt_pkg::E_BAD_TAG);
    else if (c == "\"") lex_mode = xbt_pkg::M_QUOTE;
    else if (letter(c) || c == "_" || c == "!") begin
      note(xbt_pkg::K_CONTENT, xbt_pkg::T_IDENT, c, xbt_pkg::E_BAD_TAG);
      lex_mode = xbt_pkg::M_IDENT;
    end else lex_fail(xbt_pkg::E_BAD_TAG);
  endtask

  task automatic lex_entity_char(input logic [7:0] c);
    int p;
    int h;
    logic [3:0] m;
    p = ent_len;
    m = ent_match;
    if (!(p < 2 && c == (p == 0 ? "l" : "t"))) m[0] = 1'b0;
    if (!(p < 2 && c == (p == 0 ? "g" : "t"))) m[1] = 1'b0;
    if (!(p < 3 && c == (p == 0 ? "a" : (p == 1 ? "m" : "p")))) m[2] = 1'b0;
    if (p == 0) begin
      if (c != "#") m[3] = 1'b0;
    end else if (m[3]) begin
      if (p == 1) begin
        if (c == "0") begin
          ent_base = xbt_pkg::B_ZERO;
          ent_val = 8'd0;
        end else if (digit(c)) begin
          ent_base = xbt_pkg::B_DEC;
          ent_val = c - "0";
        end else m[3] = 1'b0;
      end else if (ent_base == xbt_pkg::B_ZERO) begin
        if (c == "x" || c == "X") ent_base = xbt_pkg::B_HEX;
        else if (c >= "0" && c <= "7") begin
          ent_base = xbt_pkg::B_OCT;
          ent_val = c - "0";
        end else m[3] = 1'b0;
      end else if (ent_base == xbt_pkg::B_DEC) begin
        if (digit(c)) ent_val = ent_val * 8'd10 + (c - "0");
        else m[3] = 1'b0;
      end else if (ent_base == xbt_pkg::B_OCT) begin
        if (c >= "0" && c <= "7") ent_val = ent_val * 8'd8 + (c - "0");
        else m[3] = 1'b0;
      end else begin
        h = hex_digit(c);
        if (h >= 0) ent_val = ent_val * 8'd16 + h[7:0];
        else m[3] = 1'b0;
      end
    end
    ent_match = m;
    ent_len = p + 1;
  endtask

  task automatic lex_entity_end();
    if (ent_len == 0) begin
      lex_fail(xbt_pkg::E_EMPTY);
      return;
    end
    if (ent_match[0] && ent_len == 2)
      note(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, "<", xbt_pkg::E_BAD_TAG);
    else if (ent_match[1] && ent_len == 2)
      note(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, ">", xbt_pkg::E_BAD_TAG);
    else if (ent_match[2] && ent_len == 3)
      note(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, "&", xbt_pkg::E_BAD_TAG);
    else if (ent_match[3] && ent_len >= 2 && !(ent_base == xbt_pkg::B_HEX && ent_len == 3))
      note(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, ent_val, xbt_pkg::E_BAD_TAG);
    else begin
      lex_fail(xbt_pkg::E_UNKNOWN);
      return;
    end
    lex_mode = xbt_pkg::M_CDATA;
  endtask

  task automatic lex_end();
    case (lex_mode)
      xbt_pkg::M_TEXT: note(xbt_pkg::K_TOKEN, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
      xbt_pkg::M_CDATA: begin
        note(xbt_pkg::K_TOKEN, xbt_pkg::T_CDATA, 8'd0, xbt_pkg::E_BAD_TAG);
        note(xbt_pkg::K_TOKEN, xbt_pkg::T_END, 8'd0, xbt_pkg::E_BAD_TAG);
        lex_mode = xbt_pkg::M_TEXT;
      end
      xbt_pkg::M_LT: begin
        note(xbt_pkg::K_TOKEN, xbt_pkg::T_LT, 8'd0, xbt_pkg::E_BAD_TAG);
        lex_fail(xbt_pkg::E_EOF_TAG);
      end
      xbt_pkg::M_BANG: begin
        note(xbt_pkg::K_TOKEN, xbt_pkg::T_BANG, 8'd0, xbt_pkg::E_BAD_TAG);
        lex_fail(xbt_pkg::E_EOF_TAG);
      end
      xbt_pkg::M_BANG_DASH: lex_fail(xbt_pkg::E_BAD_COMMENT);
      xbt_pkg::M_COMMENT: lex_fail(xbt_pkg::E_EOF_COMMENT);
      xbt_pkg::M_ENTITY: lex_fail(xbt_pkg::E_EOF_ENTITY);
      xbt_pkg::M_TAG: lex_fail(xbt_pkg::E_EOF_TAG);
      xbt_pkg::M_IDENT: begin
        note(xbt_pkg::K_TOKEN, xbt_pkg::T_IDENT, 8'd0, xbt_pkg::E_BAD_TAG);
        lex_fail(xbt_pkg::E_EOF_TAG);
      end
      xbt_pkg::M_QUOTE: lex_fail(xbt_pkg::E_EOF_QUOTE);
      xbt_pkg::M_QMARK, xbt_pkg::M_SLASH: lex_fail(xbt_pkg::E_BAD_TAG);
      default: ;
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] c);
    case (lex_mode)
      xbt_pkg::M_TEXT, xbt_pkg::M_CDATA: begin
        if (lex_mode == xbt_pkg::M_TEXT && blank(c))
          note(xbt_pkg::K_SPACE, xbt_pkg::T_CDATA, c, xbt_pkg::E_BAD_TAG);
        else if (c == "<") begin
          if (lex_mode == xbt_pkg::M_CDATA)
            note(xbt_pkg::K_TOKEN, xbt_pkg::T_CDATA, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_LT;
        end else if (c == "&") begin
          ent_val = 8'd0;
          ent_base = xbt_pkg::B_DEC;
          ent_len = 0;
          ent_match = 4'hf;
          lex_mode = xbt_pkg::M_ENTITY;
        end else begin
          note(xbt_pkg::K_CONTENT, xbt_pkg::T_CDATA, c, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_CDATA;
        end
      end
      xbt_pkg::M_LT: begin
        if (c == "/") begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_CLOSE_OPEN, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
        end else if (c == "?") begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_PI_OPEN, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
        end else if (c == "!") lex_mode = xbt_pkg::M_BANG;
        else begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_LT, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
          lex_tag(c);
        end
      end
      xbt_pkg::M_BANG: begin
        if (c == "-") lex_mode = xbt_pkg::M_BANG_DASH;
        else begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_BANG, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
          lex_tag(c);
        end
      end
      xbt_pkg::M_BANG_DASH: begin
        if (c == "-") begin
          dashes = 2'd0;
          lex_mode = xbt_pkg::M_COMMENT;
        end else lex_fail(xbt_pkg::E_BAD_COMMENT);
      end
      xbt_pkg::M_COMMENT: begin
        if (c == "-") begin
          if (dashes < 2) dashes = dashes + 2'd1;
        end else if (c == ">" && dashes >= 2) begin
          dashes = 2'd0;
          lex_mode = xbt_pkg::M_TEXT;
        end else dashes = 2'd0;
      end
      xbt_pkg::M_ENTITY: begin
        if (c == ";") lex_entity_end();
        else if (!blank(c)) begin
          if (ent_len >= xbt_pkg::EntityMaxChars) lex_fail(xbt_pkg::E_TOO_LONG);
          else lex_entity_char(c);
        end
      end
      xbt_pkg::M_TAG: lex_tag(c);
      xbt_pkg::M_IDENT: begin
        if (letter(c) || digit(c) || c == "_" || c == "!" || c == ":" || c == "-")
          note(xbt_pkg::K_CONTENT, xbt_pkg::T_IDENT, c, xbt_pkg::E_BAD_TAG);
        else begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_IDENT, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
          lex_tag(c);
        end
      end
      xbt_pkg::M_QUOTE: begin
        if (c == "\"") begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_QUOTED, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TAG;
        end else note(xbt_pkg::K_CONTENT, xbt_pkg::T_QUOTED, c, xbt_pkg::E_BAD_TAG);
      end
      xbt_pkg::M_QMARK: begin
        if (c == ">") begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_PI_CLOSE, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TEXT;
        end else lex_fail(xbt_pkg::E_BAD_TAG);
      end
      xbt_pkg::M_SLASH: begin
        if (c == ">") begin
          note(xbt_pkg::K_TOKEN, xbt_pkg::T_EMPTY_CLOSE, 8'd0, xbt_pkg::E_BAD_TAG);
          lex_mode = xbt_pkg::M_TEXT;
        end else lex_fail(xbt_pkg::E_BAD_TAG);
      end
      default: ;
    endcase
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic predict_tokens(input logic [7:0] b, input bit eoi);
    step_res.delete();
    if (eoi) lex_end();
    else lex_byte(b);
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) token_q.push_back(step_res[i]);
  endtask

  task automatic send_item(input logic [7:0] b, input bit eoi);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    byte_in <= eoi ? 8'($urandom) : b;
    end_of_input <= eoi;
    do @(posedge clk); while (full);
    predict_tokens(byte_in, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Receiver: random stall before each pop (none in burst mode), with a long hold-off on request.
  int stall = 0;
  int hold_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_req && hold_cycles == 0) hold_cycles = 300;
      if (pop && !empty) stall = burst ? 0 : $urandom_range(0, 19);
      else if (stall > 0) stall--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    xbt_pkg::res_t e;
    if (!rst && pop && !empty) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d token=%0d value=%0d", $time, kind,
                 token, value);
        failures++;
      end else begin
        e = token_q.pop_front();
        if (kind != e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
          failures++;
        end
        if (token != e.token) begin
          $display("%0t: token expected %0d actual %0d", $time, e.token, token);
          failures++;
        end
        if (value != e.value) begin
          $display("%0t: value expected %0d actual %0d", $time, e.value, value);
          failures++;
        end
        if (error_code != e.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, e.error_code,
                   error_code);
          failures++;
        end
        if (last != e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, last);
          failures++;
        end
      end
    end
  end

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == "<" || c == "&");
    return c;
  endfunction

  function automatic string ident_str();
    string s;
    string head;
    string tail;
    int n;
    head = "abcxyzABCXYZ_!";
    tail = "azAZ09_!:-";
    s = "";
    s = {s, string'(head[$urandom_range(0, head.len() - 1)])};
    n = $urandom_range(0, 5);
    repeat (n) s = {s, string'(tail[$urandom_range(0, tail.len() - 1)])};
    return s;
  endfunction

  function automatic string entity_str();
    string s;
    string hexd;
    int n;
    hexd = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 5))
      0: s = "&lt;";
      1: s = "&gt;";
      2: s = "&amp;";
      3: s = $sformatf("&#%0d;", $urandom_range(0, 9999));
      4: s = $sformatf("&#0%0o;", $urandom_range(0, 4095));
      default: begin
        s = $urandom_range(0, 1) ? "&#0x" : "&#0X";
        n = $urandom_range(1, 4);
        repeat (n) s = {s, string'(hexd[$urandom_range(0, hexd.len() - 1)])};
        s = {s, ";"};
      end
    endcase
    // Whitespace within an entity is skipped.
    if ($urandom_range(0, 3) == 0) s = {s.substr(0, 1), " \t", s.substr(2, s.len() - 1)};
    return s;
  endfunction

  task automatic send_text_run();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_text($urandom_range(0, 1) ? " " : "\n");
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) send_text(entity_str());
      else send_item(pick_text_byte(), 1'b0);
    end
  endtask

  task automatic send_tag();
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 3))
      0: send_text("<?");
      1: send_text("</");
      2: send_text("<!");
      default: send_text("<");
    endcase
    send_text(ident_str());
    n = $urandom_range(0, 2);
    repeat (n) begin
      send_text(" ");
      send_text(ident_str());
      send_text($urandom_range(0, 1) ? "=\"" : " = \"");
      repeat ($urandom_range(0, 5)) begin
        do c = 8'($urandom); while (c == "\"");
        send_item(c, 1'b0);
      end
      send_text("\"");
    end
    case ($urandom_range(0, 2))
      0: send_text("?>");
      1: send_text(" />");
      default: send_text(">");
    endcase
  endtask

  task automatic send_comment();
    logic [7:0] c;
    send_text("<!--");
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom);
      send_item(c == "-" ? 8'd0 : c, 1'b0);
    end
    send_text($urandom_range(0, 1) ? "-->" : "--->");
  endtask

  task automatic send_document();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: send_text_run();
        1: send_comment();
        default: send_tag();
      endcase
    end
    send_text_run();
    send_item(8'd0, 1'b1);
  endtask

  task automatic test_directed();
    send_text("  \t<?xml v=\"1\"?>");
    send_text("<a_b:c-1! x = \"q>\" />");
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_text("\r<!DOCTYPE x><!-- a -b -- c --->");
    send_text("</a > t ");
    send_item(8'd0, 1'b1);
    send_item(8'd0, 1'b1);
  endtask

  task automatic test_entities();
    send_text("&lt;&gt;&amp;&#65;&#0101;&#0x4a;&#0XfF;&#300;&#0;&# 1 2;");
    send_text("&#00;&#00000000000077;");
    send_item(8'd0, 1'b1);
  endtask

  task automatic test_random_documents();
    while (bytes_sent < 420) begin
      burst = ($urandom_range(0, 4) == 0);
      send_document();
    end
    burst = 0;
  endtask

  task automatic test_backpressure();
    push <= 1'b0;
    hold_req = 1;
    wait (hold_cycles > 0);
    hold_req = 0;
    burst = 1;
    send_text("<abc def=\"0123456789\">some text &amp; more</abc>");
    send_item(8'd0, 1'b1);
    burst = 0;
  endtask

  // Errors are sticky, so only one error case fits in a run.
  task automatic test_error_ending();
    case ($urandom_range(0, 12))
      0: send_text("<a");
      1: send_text("<!-x");
      2: send_text("&;");
      3: send_text("&#;");
      4: send_text("&#-1;");
      5: send_text("&#0x;");
      6: send_text("<a $");
      7: send_text("&aaaaaaaaaaaaaaaaa;");
      8: send_text("<a \"q");
      9: send_text("<!-- c");
      10: send_text("&lt");
      11: send_text("<a ?x");
      default: send_text("<!");
    endcase
    send_item(8'd0, 1'b1);
    send_text("ab<c>");
    send_item(8'd0, 1'b1);
  endtask

  initial begin
    lex_mode = xbt_pkg::M_TEXT;
    dashes = 2'd0;
    ent_val = 8'd0;
    ent_base = xbt_pkg::B_DEC;
    ent_len = 0;
    ent_match = 4'hf;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_entities();
    test_random_documents();
    test_backpressure();
    test_error_ending();
    push <= 1'b0;
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && token_q.size() == 0) begin
      $display("xml_byte_tokenizer_core_tb OK");
    end else begin
      $display("xml_byte_tokenizer_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("xml_byte_tokenizer_core_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

[xml_byte_tokenizer_core.f]
hdl/xbt_pkg.sv
hdl/xbt_front.sv
hdl/xbt_back.sv
hdl/xml_byte_tokenizer_core.sv
tb/sv/xml_byte_tokenizer_core_tb.sv
